// ===== src/twa_pkg.sv =====
// Shared types and constants of the time-window average block.
package twa_pkg;

    localparam int DELAY_W     = 24;
    localparam int TIME_W      = 32;
    localparam int COUNT_OUT_W = 11;
    localparam int IN_W        = DELAY_W + TIME_W;
    localparam int OUT_USED_W  = DELAY_W + COUNT_OUT_W + 1;
    localparam int OUT_W       = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD     = OUT_W - OUT_USED_W;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd60000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVF,
        S_WRITE,
        S_CHECK_RD,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== src/time_window_average.sv =====
// Sliding time-window average of delay samples over a ring memory with a serial divider.
// Steps from the accepting edge to the result word: an eviction first if the ring was full,
// the write, a head read and a compare for each head check, a pass through the head read
// state when only the newest is left, the serial divide and the output register.
// Throughput: one word at a time; the next word is taken the cycle after the result enters
// the output register. Reset (synchronous): empty ring, zero sum, window 60000 ms.
module time_window_average #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream, tdata: [23:0] delay_value, [55:24] sample_time
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [twa_pkg::IN_W-1:0]    i_s_tdata,
    // result stream, tdata: [23:0] average_value, [34:24] kept_count, [35] ring_overflow,
    // upper bits zero
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [twa_pkg::OUT_W-1:0]   o_m_tdata,
    // window register write channel, data: window_ms
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [twa_pkg::TIME_W-1:0]  i_cfg_data
);
    import twa_pkg::*;

    localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int SW  = DELAY_W + CW;
    localparam int SCW = $clog2(SW + 1);

    // Ring memory: each entry holds {delay, time stamp}.
    logic [IN_W-1:0]    r_mem [RING_DEPTH];
    logic [IN_W-1:0]    r_rd_data;

    t_state             r_state;
    t_state             n_state;

    logic [TIME_W-1:0]  r_window;
    logic [DELAY_W-1:0] r_value;
    logic [TIME_W-1:0]  r_now;
    logic               r_ovf;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [SW-1:0]      r_sum;
    logic [CW-1:0]      r_rem;
    logic [SW-1:0]      r_quo;
    logic [SCW-1:0]     r_step;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               in_take;
    logic               ring_full;
    logic               multi;
    logic [TIME_W-1:0]  age;
    logic               inside_win;
    logic [DELAY_W-1:0] rd_delay;
    logic [CW:0]        trial;
    logic               trial_ge;
    logic [CW-1:0]      n_rem;
    logic               div_last;
    logic               out_free;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos);
        next_pos = (pos == AW'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    assign ring_full  = (r_count == CW'(RING_DEPTH));
    assign multi      = (r_count > CW'(1));
    assign rd_delay   = r_rd_data[IN_W-1:TIME_W];
    // modular age of the oldest kept sample
    assign age        = r_now - r_rd_data[TIME_W-1:0];
    assign inside_win = (age <= r_window);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // One restoring divide step: shift in the next dividend bit, subtract when it fits.
    assign trial    = {r_rem, r_quo[SW-1]};
    assign trial_ge = (trial >= {1'b0, r_count});
    assign n_rem    = trial_ge ? CW'(trial - {1'b0, r_count}) : CW'(trial);
    assign div_last = (r_step == SCW'(SW - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ring_full ? S_OVF : S_WRITE;
                end
            end
            S_OVF:      n_state = S_WRITE;
            S_WRITE:    n_state = S_CHECK_RD;
            S_CHECK_RD: n_state = multi ? S_CHECK : S_DIV;
            S_CHECK:    n_state = inside_win ? S_DIV : S_CHECK_RD;
            S_DIV: begin
                if (div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Control outputs: memory strobes and input ready
    always_comb begin
        o_s_tready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        wr_en      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                // fetch the oldest entry now in case the ring is full
                rd_en      = i_s_tvalid && ring_full;
            end
            S_WRITE:    wr_en = 1'b1;
            S_CHECK_RD: rd_en = multi;
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Ring memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= {r_value, r_now};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // drop the result word once taken, unless a new one replaces it now
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_OVF: begin
                    // drop the oldest to make room
                    r_sum   <= r_sum - SW'(rd_delay);
                    r_head  <= next_pos(r_head);
                    r_count <= r_count - 1'b1;
                end
                S_WRITE: begin
                    r_tail  <= next_pos(r_tail);
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SW'(r_value);
                end
                S_CHECK: begin
                    if (!inside_win) begin
                        r_sum   <= r_sum - SW'(rd_delay);
                        r_head  <= next_pos(r_head);
                        r_count <= r_count - 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    // Payload: captured word, divider and result register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_value <= i_s_tdata[DELAY_W-1:0];
            r_now   <= i_s_tdata[IN_W-1:DELAY_W];
            r_ovf   <= ring_full;
        end
        // load the divider on the way into the divide state
        if ((r_state == S_CHECK_RD && !multi) || (r_state == S_CHECK && inside_win)) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == S_DIV) begin
            r_quo  <= {r_quo[SW-2:0], trial_ge};
            r_rem  <= n_rem;
            r_step <= r_step + 1'b1;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data <= {{OUT_PAD{1'b0}}, r_ovf, COUNT_OUT_W'(r_count),
                           r_quo[DELAY_W-1:0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_DEPTH))
        else $error("ring count above depth");

    a_check_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> multi)
        else $error("head check with a single sample");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0))
        else $error("divide by zero count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !o_s_tready)
        else $error("second word taken while busy");
`endif

endmodule

// ===== sim/twa_checker.sv =====
// Checker for the time-window average: watches the three channels, predicts each result and compares.
module twa_checker
    import twa_pkg::*;
#(
    parameter int RING = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample stream, tdata: [23:0] delay_value, [55:24] sample_time
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,
    // result stream, tdata: [23:0] average_value, [34:24] kept_count, [35] ring_overflow
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [OUT_W-1:0]  i_m_tdata,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [TIME_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count,
    output int                o_overflow_count
);

    localparam int AWAIT_DEPTH = 8;

    typedef struct {
        logic [DELAY_W-1:0]     average;
        logic [COUNT_OUT_W-1:0] kept;
        logic                   overflow;
    } t_window_result;

    // Own copy of the ring, its pointers, the running total and the window.
    logic [DELAY_W-1:0] delay_ring [RING];
    logic [TIME_W-1:0]  stamp_ring [RING];
    int unsigned        oldest_pos;
    int unsigned        write_pos;
    int unsigned        held;
    longint unsigned    delay_total;
    logic [TIME_W-1:0]  window_limit;

    // Predicted results waiting for their word, oldest at await_rd.
    t_window_result     awaited [AWAIT_DEPTH];
    int unsigned        await_rd;
    int unsigned        await_wr;
    t_window_result     wanted;
    logic [DELAY_W-1:0]     got_average;
    logic [COUNT_OUT_W-1:0] got_kept;
    logic                   got_overflow;
    logic [OUT_PAD-1:0]     got_pad;
    int                 fails;
    int                 results;
    int                 overflows;

    function automatic void evict_oldest();
        delay_total -= delay_ring[oldest_pos];
        oldest_pos = (oldest_pos + 1 == RING) ? 0 : oldest_pos + 1;
        held--;
    endfunction

    function automatic t_window_result predict_average(input logic [DELAY_W-1:0] delay,
                                                       input logic [TIME_W-1:0]  stamp);
        t_window_result r;
        r.overflow = 1'b0;
        // full ring: force out the oldest first, whatever the window says
        if (held >= RING) begin
            evict_oldest();
            r.overflow = 1'b1;
        end
        delay_ring[write_pos] = delay;
        stamp_ring[write_pos] = stamp;
        write_pos = (write_pos + 1 == RING) ? 0 : write_pos + 1;
        held++;
        delay_total += delay;
        // ages are modular; the newest sample always stays
        while (held > 1 && TIME_W'(stamp - stamp_ring[oldest_pos]) > window_limit)
            evict_oldest();
        r.average = DELAY_W'(delay_total / held);
        r.kept    = COUNT_OUT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            oldest_pos   = 0;
            write_pos    = 0;
            held         = 0;
            delay_total  = 0;
            window_limit = WINDOW_RESET;
            await_rd     = 0;
            await_wr     = 0;
            fails        = 0;
            results      = 0;
            overflows    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                window_limit = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                {got_pad, got_overflow, got_kept, got_average} = i_m_tdata;
                if (await_wr == await_rd) begin
                    fails++;
                    if (fails <= 10)
                        $display("checker: unexpected result word %h", i_m_tdata);
                end else begin
                    wanted = awaited[await_rd % AWAIT_DEPTH];
                    await_rd++;
                    results++;
                    if (wanted.overflow)
                        overflows++;
                    if (got_average !== wanted.average || got_kept !== wanted.kept ||
                        got_overflow !== wanted.overflow || got_pad !== '0) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("checker: result %0d expected avg %h kept %0d ovf %0d",
                                     results, wanted.average, wanted.kept, wanted.overflow);
                            $display("checker:   got avg %h kept %0d ovf %0d pad %h",
                                     got_average, got_kept, got_overflow, got_pad);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (await_wr - await_rd >= AWAIT_DEPTH) begin
                    fails++;
                    if (fails <= 10)
                        $display("checker: too many results outstanding");
                end else begin
                    awaited[await_wr % AWAIT_DEPTH] = predict_average(
                        i_s_tdata[DELAY_W-1:0], i_s_tdata[IN_W-1:DELAY_W]);
                    await_wr++;
                end
            end
        end
        o_fail_count     <= fails;
        o_pending        <= int'(await_wr - await_rd);
        o_result_count   <= results;
        o_overflow_count <= overflows;
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the time-window average bench: clock, reset, sample stimulus and the verdict.
module testbench;
    import twa_pkg::*;

    localparam int RING_DEPTH     = 1024;
    localparam int CLK_PERIOD     = 12;
    // room for a full-ring eviction walk several times over
    localparam int WATCHDOG_LIMIT = 12000;
    // the block is idle once its last result has gone; a short settle is enough
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [TIME_W-1:0] WINDOW_ALL_ONES = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    // tdata: [23:0] delay_value, [55:24] sample_time
    logic [IN_W-1:0]     i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    // tdata: [23:0] average_value, [34:24] kept_count, [35] ring_overflow, rest zero
    logic [OUT_W-1:0]    o_m_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TIME_W-1:0]   i_cfg_data;

    int                  fail_count;
    int                  pending;
    int                  result_count;
    int                  overflow_count;
    int                  samples_sent;
    int                  idle_cycles;
    logic                steady;
    logic [TIME_W-1:0]   clock_ms;

    time_window_average #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    twa_checker #(
        .RING (RING_DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_overflow_count (overflow_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Result side: stall about 29 percent of the time, never while the steady stretch runs.
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 29);
    end

    // Watchdog: count cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Pick a delay: a mix of tiny values, values near the top and anything at all.
    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(3))
            0:       return DELAY_W'($urandom_range(255));
            1:       return {DELAY_W{1'b1}} - DELAY_W'($urandom_range(255));
            default: return DELAY_W'($urandom());
        endcase
    endfunction

    // Offer one sample word and hold it until the block takes it. On return, valid is
    // still high: the next call either keeps it high or drops it for a gap.
    task automatic send_sample(input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] stamp);
        while (!steady && $urandom_range(99) < 29) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {stamp, delay};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        samples_sent++;
    endtask

    // Write the window only once the block has delivered every outstanding result.
    task automatic set_window(input logic [TIME_W-1:0] value);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Advance the clock in random steps; a share of samples carry a stamp from anywhere, which
    // mostly looks far ahead or far behind and, under a short window, clears the ring down to the newest sample.
    task automatic run_phase(input int count, input int max_step, input int stray_pct);
        logic [TIME_W-1:0] stamp;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < stray_pct) begin
                stamp = $urandom();
            end else begin
                clock_ms += $urandom_range(max_step);
                stamp = clock_ms;
            end
            send_sample(pick_delay(), stamp);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        steady       = 1'b0;
        samples_sent = 0;
        clock_ms     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default window straight after reset: extremes, edge of the window, one past it.
        send_sample({DELAY_W{1'b1}}, 32'd0);
        send_sample('0, 32'd60000);
        send_sample(24'h123456, 32'd60001);
        // stamp behind the stored ones: they look very old and go
        send_sample(24'd1, 32'd5);
        // wrap of the millisecond counter: a small modular age survives
        send_sample(24'h800000, 32'hFFFF_FFF0);
        send_sample(24'h7FFFFF, 32'h0000_0010);
        send_sample(24'hAAAAAA, 32'h5555_5555);
        send_sample(24'h555555, 32'hAAAAAAAA);

        // Zero window: equal stamps are kept, one millisecond later only the newest stays.
        set_window('0);
        send_sample(24'd100, 32'd7000);
        send_sample(24'd300, 32'd7000);
        send_sample(24'd55, 32'd7001);
        send_sample(24'd77, 32'd7001);

        // All-ones window: nothing is ever old enough to go.
        set_window(WINDOW_ALL_ONES);
        send_sample(24'd10, 32'd0);
        send_sample(24'hFFFFFE, 32'h8000_0000);
        send_sample(24'd0, 32'hFFFF_FFFF);

        // Random part. Moderate window, steady clock with some stray stamps.
        set_window($urandom_range(20000, 2000));
        run_phase(270, 1000, 5);

        // Zero window with steps of zero or one millisecond, no idling on either side.
        set_window('0);
        steady <= 1'b1;
        run_phase(100, 1, 3);

        // All-ones window: fill the ring and keep pushing so the oldest is forced out.
        set_window(WINDOW_ALL_ONES);
        run_phase(200, 50, 0);
        steady <= 1'b0;
        run_phase(900, 50, 0);

        // Short window and a large jump: one step clears a full ring down to one sample.
        set_window(32'd1000);
        clock_ms += 32'd1_000_000;
        send_sample(pick_delay(), clock_ms);
        run_phase(60, 100, 3);

        // Random window with stamps from anywhere.
        set_window($urandom());
        run_phase(100, 0, 100);

        // Drain: drop valid, wait for the last result, then let the block settle.
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples sent with windows zero to all-ones, %0d results checked",
                 samples_sent, result_count);
        $display("summary: %0d results carried the ring overflow flag", overflow_count);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/twa_pkg.sv
src/time_window_average.sv
sim/twa_checker.sv
sim/testbench.sv
